@@ rtl/core/stepseq_pkg.sv @@
// ----------------------------------------------------------------------------
// Stepper phase sequencer package
// Shared types, register codes and coil tables for the stepper sequencer.
// ----------------------------------------------------------------------------
package stepseq_pkg;

  // Number of axes that exist, between one and AXIS_MAX.
  localparam int AXIS_COUNT = 4;
  // Number of axis slots in the transaction fields.
  localparam int AXIS_MAX   = 4;

  // Configuration register indexes.
  localparam logic [2:0] REG_ACTIVE    = 3'd0;
  localparam logic [2:0] REG_FOUR_PIN  = 3'd1;
  localparam logic [2:0] REG_FULL_STEP = 3'd2;
  localparam logic [2:0] REG_ENABLE1   = 3'd3;
  localparam logic [2:0] REG_ENABLE2   = 3'd4;

  // Command codes carried in the mode field.
  localparam logic MODE_STEP   = 1'b0;
  localparam logic MODE_ENABLE = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] steps_axis0;
    logic [7:0] steps_axis1;
    logic [7:0] steps_axis2;
    logic [7:0] steps_axis3;
    logic [3:0] direction_bits;
    logic [1:0] target_axis;
    logic       enable_on;
    logic       force_phase;
  } step_item_t;

  typedef struct packed {
    logic [15:0] coil_pins;
    logic [7:0]  enable_pins;
    logic [3:0]  enabled_status;
  } result_item_t;

  // Per-axis configuration bits.
  typedef struct packed {
    logic active;
    logic four_pin;
    logic full_step;
    logic enable1;
    logic enable2;
  } lane_cfg_t;

  // Per-axis slice of one command.
  typedef struct packed {
    logic       mode;
    logic [7:0] steps;
    logic       count_up;
    logic       selected;
    logic       enable_on;
    logic       force_phase;
  } lane_cmd_t;

  // Levels an axis shows after the current command.
  typedef struct packed {
    logic [3:0] coils;
    logic [1:0] enables;
    logic       enabled;
  } lane_out_t;

  function automatic logic [3:0] half4_coils(input logic [2:0] idx);
    logic [3:0] c;
    case (idx)
      3'd0:    c = 4'd10;
      3'd1:    c = 4'd8;
      3'd2:    c = 4'd9;
      3'd3:    c = 4'd1;
      3'd4:    c = 4'd5;
      3'd5:    c = 4'd4;
      3'd6:    c = 4'd6;
      default: c = 4'd2;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] full4_coils(input logic [1:0] idx);
    logic [3:0] c;
    case (idx)
      2'd0:    c = 4'd10;
      2'd1:    c = 4'd9;
      2'd2:    c = 4'd5;
      default: c = 4'd6;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] full2_coils(input logic [1:0] idx);
    logic [3:0] c;
    case (idx)
      2'd0:    c = 4'd3;
      2'd1:    c = 4'd2;
      2'd2:    c = 4'd0;
      default: c = 4'd1;
    endcase
    return c;
  endfunction

  // Coil levels for a step index under the axis's table choice.
  function automatic logic [3:0] phase_coils(input lane_cfg_t cfg, input logic [2:0] idx);
    logic [3:0] c;
    if (!cfg.four_pin) begin
      c = full2_coils(idx[1:0]);
    end else if (cfg.full_step) begin
      c = full4_coils(idx[1:0]);
    end else begin
      c = half4_coils(idx);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/stepseq_lane.sv @@
// ----------------------------------------------------------------------------
// Stepper sequencer axis lane
// Holds one axis's step index, coil and enable levels and applies a command.
// ----------------------------------------------------------------------------
module stepseq_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  stepseq_pkg::lane_cfg_t cfg,
  input  stepseq_pkg::lane_cmd_t cmd,
  output stepseq_pkg::lane_out_t levels
);
  import stepseq_pkg::*;

  logic [2:0] step_index;
  logic [3:0] coil_levels;
  logic [1:0] enable_levels;
  logic [2:0] step_index_next;
  logic [3:0] coil_levels_next;
  logic [1:0] enable_levels_next;
  logic       enabled_next;

  always_comb begin
    step_index_next    = step_index;
    coil_levels_next   = coil_levels;
    enable_levels_next = enable_levels;
    if (cmd.mode == MODE_STEP) begin
      if (cmd.steps != 8'd0) begin
        // Only the low three bits of the count matter modulo eight.
        if (cmd.count_up) begin
          step_index_next = step_index + cmd.steps[2:0];
        end else begin
          step_index_next = step_index - cmd.steps[2:0];
        end
        if (cfg.active) begin
          coil_levels_next = phase_coils(cfg, step_index_next);
        end
      end
    end else if (cmd.selected && cfg.active) begin
      if (cfg.enable1) begin
        enable_levels_next[0] = cmd.enable_on;
        if (cfg.enable2) begin
          enable_levels_next[1] = cmd.enable_on;
        end
      end else if (cfg.four_pin) begin
        if (!cmd.enable_on) begin
          coil_levels_next = 4'd0;
        end else if (cmd.force_phase) begin
          coil_levels_next = phase_coils(cfg, step_index);
        end
      end
    end
  end

  always_comb begin
    if (!cfg.active) begin
      enabled_next = 1'b0;
    end else if (cfg.enable1) begin
      enabled_next = enable_levels_next[0] && (!cfg.enable2 || enable_levels_next[1]);
    end else if (!cfg.four_pin) begin
      enabled_next = 1'b1;
    end else begin
      enabled_next = coil_levels_next != 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index    <= 3'd0;
      coil_levels   <= 4'd0;
      enable_levels <= 2'd0;
    end else if (accept) begin
      step_index    <= step_index_next;
      coil_levels   <= coil_levels_next;
      enable_levels <= enable_levels_next;
    end
  end

  assign levels.coils   = coil_levels_next;
  assign levels.enables = enable_levels_next;
  assign levels.enabled = enabled_next;

endmodule

@@ rtl/core/stepseq_merge.sv @@
// ----------------------------------------------------------------------------
// Stepper sequencer result merge
// Packs the lane levels into a result and buffers it in an output register
// backed by a skid register.
// ----------------------------------------------------------------------------
module stepseq_merge (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          accept,
  input  stepseq_pkg::lane_out_t [stepseq_pkg::AXIS_MAX-1:0] lanes,
  output logic                                          busy,
  output logic                                          result_valid,
  input  logic                                          result_stall,
  output stepseq_pkg::result_item_t                     result
);
  import stepseq_pkg::*;

  result_item_t merged;
  result_item_t skid;
  logic         skid_valid;
  logic         out_fire;

  always_comb begin
    for (int a = 0; a < AXIS_MAX; a++) begin
      merged.coil_pins[4*a +: 4]   = lanes[a].coils;
      merged.enable_pins[2*a +: 2] = lanes[a].enables;
      merged.enabled_status[a]     = lanes[a].enabled;
    end
  end

  assign out_fire = result_valid && !result_stall;
  assign busy     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_fire) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!accept) begin
        result_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!result_valid) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (skid_valid) begin
        result <= skid;
      end else if (accept) begin
        result <= merged;
      end
    end else if (accept) begin
      if (!result_valid) begin
        result <= merged;
      end else begin
        skid <= merged;
      end
    end
  end

endmodule

@@ rtl/core/stepper_phase_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// Stepper phase sequencer
// Four-axis bipolar stepper coil driver with half-step and full-step tables.
// ----------------------------------------------------------------------------
// Each accepted step transaction moves every axis with a nonzero count by that
// count modulo eight and redrives the coils of each such axis that is active,
// and each enable transaction switches one active axis; either kind returns
// exactly one result transaction with all coil pins, enable pins and the
// enabled status as they stand after the command. The block takes one
// transaction per clock cycle while step_stall is low and registers each result
// in the output register, or in the skid register while a stalled result waits.
// The per-axis lanes each apply a small add and a table lookup combinationally.
// An output register plus a skid register lets a new transaction be accepted
// while a result waits; step_stall rises only when both hold results.
// Configuration writes must be issued only while the block is idle.
module stepper_phase_sequencer_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [3:0]                cfg_data,
  input  logic                      step_valid,
  output logic                      step_stall,
  input  stepseq_pkg::step_item_t   step_item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output stepseq_pkg::result_item_t result
);
  import stepseq_pkg::*;

  logic [3:0] active_axes;
  logic [3:0] four_pin_axes;
  logic [3:0] full_step_axes;
  logic [3:0] enable1_axes;
  logic [3:0] enable2_axes;

  logic                     accept;
  logic                     busy;
  logic [AXIS_MAX-1:0][7:0] steps;
  lane_out_t [AXIS_MAX-1:0] lanes;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_axes    <= 4'hF;
      four_pin_axes  <= 4'hF;
      full_step_axes <= 4'h0;
      enable1_axes   <= 4'h0;
      enable2_axes   <= 4'h0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE:    active_axes    <= cfg_data;
        REG_FOUR_PIN:  four_pin_axes  <= cfg_data;
        REG_FULL_STEP: full_step_axes <= cfg_data;
        REG_ENABLE1:   enable1_axes   <= cfg_data;
        REG_ENABLE2:   enable2_axes   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign step_stall = busy;
  assign accept     = step_valid && !step_stall;

  assign steps[0] = step_item.steps_axis0;
  assign steps[1] = step_item.steps_axis1;
  assign steps[2] = step_item.steps_axis2;
  assign steps[3] = step_item.steps_axis3;

  // One lane per existing axis; missing axes read as zero.
  for (genvar a = 0; a < AXIS_MAX; a++) begin : g_axis
    if (a < AXIS_COUNT) begin : g_lane
      lane_cfg_t lane_cfg;
      lane_cmd_t lane_cmd;

      assign lane_cfg.active    = active_axes[a];
      assign lane_cfg.four_pin  = four_pin_axes[a];
      assign lane_cfg.full_step = full_step_axes[a];
      assign lane_cfg.enable1   = enable1_axes[a];
      assign lane_cfg.enable2   = enable2_axes[a];

      assign lane_cmd.mode        = step_item.mode;
      assign lane_cmd.steps       = steps[a];
      assign lane_cmd.count_up    = step_item.direction_bits[a];
      assign lane_cmd.selected    = step_item.target_axis == 2'(a);
      assign lane_cmd.enable_on   = step_item.enable_on;
      assign lane_cmd.force_phase = step_item.force_phase;

      stepseq_lane u_lane (
        .clk    (clk),
        .rst    (rst),
        .accept (accept),
        .cfg    (lane_cfg),
        .cmd    (lane_cmd),
        .levels (lanes[a])
      );
    end else begin : g_absent
      assign lanes[a] = '0;
    end
  end

  stepseq_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .lanes        (lanes),
    .busy         (busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTHESIS
  // A transaction is held off only while a result is already waiting.
  assert property (@(posedge clk) disable iff (rst) step_stall |-> result_valid)
    else $error("input stalled with an empty output register");

  // Every accepted transaction leaves a result in the output register.
  assert property (@(posedge clk) disable iff (rst) accept |=> result_valid)
    else $error("accepted transaction produced no result");

  // With nothing accepted and the result taken, the output drains.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !step_stall && !accept) |=> !result_valid)
    else $error("result repeated after it was taken");

  // A stalled output with a free skid stage still accepts and then fills it.
  assert property (@(posedge clk) disable iff (rst)
    (accept && result_valid && result_stall) |=> step_stall)
    else $error("result lost while the output was stalled");
`endif

endmodule
